### src/r2h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV pixel core package
// Transaction types, conversion constants and the divider step function.
// ----------------------------------------------------------------------------
package r2h_pkg;

  localparam logic [7:0] FULL_SCALE   = 8'd255;
  localparam logic [7:0] HUE_STEP     = 8'd43;
  localparam logic [7:0] OFFSET_RED   = 8'd0;
  localparam logic [7:0] OFFSET_GREEN = 8'd85;
  localparam logic [7:0] OFFSET_BLUE  = 8'd171;

  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] spread;
    logic [7:0] mag;
    logic [7:0] offset;
    logic       neg;
    logic       hue_zero;
    logic       sat_zero;
  } front_t;

  typedef struct packed {
    logic [15:0] rem_sat;
    logic [15:0] rem_hue;
    logic [7:0]  dsr_sat;
    logic [7:0]  dsr_hue;
    logic [7:0]  q_sat;
    logic [7:0]  q_hue;
    logic [7:0]  offset;
    logic        neg;
    logic        hue_zero;
    logic        sat_zero;
  } div_t;

  typedef struct packed {
    logic [15:0] rem;
    logic        qbit;
  } step_t;

  // One restoring division step at quotient bit bit_idx.
  function automatic step_t div_step(input logic [15:0] rem, input logic [7:0] dsr,
                                     input logic [2:0] bit_idx);
    logic [15:0] trial;
    step_t       res;
    trial = {8'd0, dsr} << bit_idx;
    if (rem >= trial) begin
      res.rem  = rem - trial;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### src/rgb_to_hsv_pixel_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV pixel core
// Converts one 8-bit RGB pixel per transaction into 8-bit hue, saturation
// and brightness.
//
// The input channel carries one pixel per transaction on in_data, and the
// result channel carries one HSV result per transaction on out_data. Both
// channels transfer when valid is high and stall is low.
// While out_stall is low, the pipeline accepts one pixel every cycle: a front
// stage finds the maximum, minimum and sector, a product stage forms the
// dividends, four divider stages resolve two quotient bits each, and an
// output register applies the sector offset.
// When the receiver stalls, each stage holds its transaction and empty stages
// upstream keep filling, so input is stalled only once the pipeline is full.
// Reset clears all valid bits; nothing else needs clearing.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire r2h_pkg::pix_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output r2h_pkg::pix_out_t     out_data
);
  import r2h_pkg::*;

  front_t   s1_r;
  front_t   s1_nxt;
  logic     s1_v_r;
  logic     s1_en;

  div_t     dv_r   [0:DIV_STAGES];
  div_t     dv_nxt [0:DIV_STAGES];
  logic     dv_v_r [0:DIV_STAGES];
  logic [DIV_STAGES:0] dv_en;

  pix_out_t out_r;
  pix_out_t out_nxt;
  logic     out_valid_r;
  logic     out_en;

  always_comb begin
    out_en = !out_valid_r || !out_stall;
    dv_en[DIV_STAGES] = !dv_v_r[DIV_STAGES] || out_en;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      dv_en[k] = !dv_v_r[k] || dv_en[k+1];
    end
    s1_en = !s1_v_r || dv_en[0];
  end

  assign in_stall  = !s1_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] a;
    logic [7:0] b;
    hi = (in_data.red > in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue > hi) begin
      hi = in_data.blue;
    end
    lo = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue < lo) begin
      lo = in_data.blue;
    end
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      a = in_data.green;
      b = in_data.blue;
      s1_nxt.offset = OFFSET_RED;
    end else if (in_data.green >= in_data.blue) begin
      a = in_data.blue;
      b = in_data.red;
      s1_nxt.offset = OFFSET_GREEN;
    end else begin
      a = in_data.red;
      b = in_data.green;
      s1_nxt.offset = OFFSET_BLUE;
    end
    s1_nxt.brightness = hi;
    s1_nxt.spread     = hi - lo;
    s1_nxt.neg        = a < b;
    s1_nxt.mag        = (a >= b) ? a - b : b - a;
    s1_nxt.hue_zero   = hi == lo;
    s1_nxt.sat_zero   = hi == 8'd0;
  end

  always_comb begin
    logic [15:0] sat_prod;
    logic [15:0] hue_prod;
    sat_prod = 16'(FULL_SCALE) * {8'd0, s1_r.spread};
    hue_prod = 16'(HUE_STEP) * {8'd0, s1_r.mag};
    dv_nxt[0].rem_sat  = sat_prod;
    dv_nxt[0].rem_hue  = hue_prod;
    dv_nxt[0].dsr_sat  = s1_r.brightness;
    dv_nxt[0].dsr_hue  = s1_r.spread;
    dv_nxt[0].q_sat    = 8'd0;
    dv_nxt[0].q_hue    = 8'd0;
    dv_nxt[0].offset   = s1_r.offset;
    dv_nxt[0].neg      = s1_r.neg;
    dv_nxt[0].hue_zero = s1_r.hue_zero;
    dv_nxt[0].sat_zero = s1_r.sat_zero;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam logic [2:0] BitHi = 3'(2 * (DIV_STAGES - k) + 1);
    localparam logic [2:0] BitLo = 3'(2 * (DIV_STAGES - k));
    always_comb begin
      step_t s_hi;
      step_t s_lo;
      step_t h_hi;
      step_t h_lo;
      s_hi = div_step(dv_r[k-1].rem_sat, dv_r[k-1].dsr_sat, BitHi);
      s_lo = div_step(s_hi.rem, dv_r[k-1].dsr_sat, BitLo);
      h_hi = div_step(dv_r[k-1].rem_hue, dv_r[k-1].dsr_hue, BitHi);
      h_lo = div_step(h_hi.rem, dv_r[k-1].dsr_hue, BitLo);
      dv_nxt[k]                = dv_r[k-1];
      dv_nxt[k].rem_sat        = s_lo.rem;
      dv_nxt[k].rem_hue        = h_lo.rem;
      dv_nxt[k].q_sat[BitHi]   = s_hi.qbit;
      dv_nxt[k].q_sat[BitLo]   = s_lo.qbit;
      dv_nxt[k].q_hue[BitHi]   = h_hi.qbit;
      dv_nxt[k].q_hue[BitLo]   = h_lo.qbit;
    end
  end

  always_comb begin
    div_t d;
    d = dv_r[DIV_STAGES];
    out_nxt.brightness = d.dsr_sat;
    out_nxt.saturation = d.sat_zero ? 8'd0 : d.q_sat;
    if (d.hue_zero) begin
      out_nxt.hue = 8'd0;
    end else if (d.neg) begin
      out_nxt.hue = d.offset - d.q_hue;
    end else begin
      out_nxt.hue = d.offset + d.q_hue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else begin
      if (s1_en) begin
        s1_v_r <= in_valid;
      end
      if (dv_en[0]) begin
        dv_v_r[0] <= s1_v_r;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (dv_en[k]) begin
          dv_v_r[k] <= dv_v_r[k-1];
        end
      end
      if (out_en) begin
        out_valid_r <= dv_v_r[DIV_STAGES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (dv_en[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
    if (out_en) begin
      out_r <= out_nxt;
    end
  end

  a_accept_fills_front : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_v_r)
    else $error("Accepted transaction did not reach the front stage.");

  a_sat_remainder : assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DIV_STAGES] && !dv_r[DIV_STAGES].sat_zero
      |-> dv_r[DIV_STAGES].rem_sat < {8'd0, dv_r[DIV_STAGES].dsr_sat})
    else $error("Saturation divider remainder is not below the divisor.");

  a_hue_quotient : assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DIV_STAGES] && !dv_r[DIV_STAGES].hue_zero
      |-> dv_r[DIV_STAGES].rem_hue < {8'd0, dv_r[DIV_STAGES].dsr_hue}
          && dv_r[DIV_STAGES].q_hue <= HUE_STEP)
    else $error("Hue divider result is out of range.");

  a_black_output : assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DIV_STAGES] && dv_en[DIV_STAGES] && dv_r[DIV_STAGES].sat_zero
      |=> out_valid_r && out_r == '0)
    else $error("Black pixel did not give an all-zero result.");

  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !dv_v_r[DIV_STAGES] |=> !out_valid_r)
    else $error("Output stayed valid after its transaction was taken.");

endmodule
`default_nettype wire
